// ===== rtl/micdcb_pkg.sv =====
package micdcb_pkg;

  // field and datapath widths
  localparam int RAW_W    = 32;
  localparam int X_W      = 23;  // raw word after a right shift of at least 9
  localparam int Y_W      = 34;  // unclamped filter sum, never overflows this
  localparam int FILT_W   = 32;  // stored filter output (wraps)
  localparam int PCM_W    = 16;
  localparam int MAG_W    = 16;
  localparam int CNT_W    = 21;
  localparam int ENG_W    = 51;
  localparam int GAIN_W   = 3;
  localparam int COEF_W   = 10;
  localparam int FB_SHIFT = 10;
  localparam int SQ_W     = 2 * MAG_W;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;
  localparam int DIGIT_W  = 8;

  // operation codes
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_START  = 2'd1;
  localparam logic [1:0] OP_STOP   = 2'd2;

  // register indexes (word address)
  localparam logic [1:0] REG_GAIN = 2'd0;
  localparam logic [1:0] REG_COEF = 2'd1;
  localparam logic [1:0] REG_MAX  = 2'd2;

  // register reset values
  localparam logic [GAIN_W-1:0] GAIN_RESET = 3'd0;
  localparam logic [COEF_W-1:0] COEF_RESET = 10'd1013;
  localparam logic [CNT_W-1:0]  MAX_RESET  = 21'd1048576;

  localparam logic [4:0] BASE_SHIFT = 5'd16;

  // saturation bounds
  localparam logic signed [Y_W-1:0] PCM_MAX = 34'sd32767;
  localparam logic signed [Y_W-1:0] PCM_MIN = -34'sd32768;
  localparam logic [ENG_W-1:0]      ENERGY_MAX = {ENG_W{1'b1}};

  typedef struct packed {
    logic [1:0]              operation;
    logic signed [RAW_W-1:0] raw_word;
  } in_item_t;

  typedef struct packed {
    logic signed [PCM_W-1:0] pcm_sample;
    logic                    sample_valid;
    logic                    is_recording;
    logic [CNT_W-1:0]        samples_stored;
    logic [MAG_W-1:0]        peak_level;
    logic [ENG_W-1:0]        energy_sum;
  } out_item_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_bits;
    logic [COEF_W-1:0] dc_coefficient;
    logic [CNT_W-1:0]  max_samples;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FB,
    ST_SAT,
    ST_SQ,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/mic_sample_dc_block_capture_unit.sv =====
// Microphone capture with DC blocking filter and level statistics.
// Input channel (in_valid/in_ready/in_data) takes one item per command:
// a microphone word, a start or a stop. Every item gives exactly one
// result on the output channel (out_valid/out_ready/out_data) with the
// filtered sample (when stored) and the capture state after the item.
// Settings are to be written over the APB-style port only while the block
// is idle; the block itself does not enforce this. For a stored sample
// the feedback product runs through a digit-serial multiplier 8 bits
// per cycle, then come the filter sum, saturation, a digit-serial square
// for the energy, and the result load. Start, stop and ignored items go
// straight to the final state. One item is in work at a time; in_ready
// is high only while no item is in work. The result sits in an output
// register; a finished item waits in the final state while the receiver
// stalls, and the next item is accepted as soon as that result is
// loaded. Reset clears the filter, the count, the statistics and the
// recording flag and loads the register defaults.
module mic_sample_dc_block_capture_unit #(
  parameter int unsigned CAPACITY_LIMIT = 1048576
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  micdcb_pkg::in_item_t           in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output micdcb_pkg::out_item_t          out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [micdcb_pkg::PADDR_W-1:0] paddr,
  input  logic [micdcb_pkg::PDATA_W-1:0] pwdata,
  output logic [micdcb_pkg::PDATA_W-1:0] prdata,
  output logic                           pready
);

  localparam int CNT_W = micdcb_pkg::CNT_W;
  localparam int Y_W   = micdcb_pkg::Y_W;
  localparam int X_W   = micdcb_pkg::X_W;
  localparam int FW    = micdcb_pkg::FILT_W;
  localparam int PROD_W = FW + micdcb_pkg::COEF_W;
  localparam logic [CNT_W-1:0] CAP_LIM = CNT_W'(CAPACITY_LIMIT);

  micdcb_pkg::cfg_t cfg;

  micdcb_pkg::state_t state_r, state_nxt;

  // filter and capture state
  logic signed [X_W-1:0]          prev_in_r, prev_in_nxt;
  logic [FW-1:0]                  prev_out_r, prev_out_nxt;
  logic                           rec_r, rec_nxt;
  logic [CNT_W-1:0]               count_r, count_nxt;
  logic [micdcb_pkg::MAG_W-1:0]   peak_r, peak_nxt;
  logic [micdcb_pkg::ENG_W-1:0]   energy_r, energy_nxt;

  // per-item working registers
  logic signed [X_W-1:0]          x_r, x_nxt;
  logic signed [Y_W-1:0]          y_r, y_nxt;
  logic [micdcb_pkg::PCM_W-1:0]   pcm_r, pcm_nxt;
  logic                           valid_r, valid_nxt;

  // output register
  logic                           out_valid_r, out_valid_nxt;
  micdcb_pkg::out_item_t          out_data_r, out_data_nxt;

  // control
  logic accept, path_sample, fb_start, sq_start, out_load;
  logic fb_done, sq_done;
  logic [CNT_W-1:0] cap;

  // datapath helpers
  logic [PROD_W-1:0]             fb_prod;
  logic signed [FW-1:0]          fb;
  logic signed [Y_W-1:0]         y_sum;
  logic signed [Y_W-1:0]         y_sat;
  logic [micdcb_pkg::MAG_W-1:0]  mag;
  logic [micdcb_pkg::SQ_W-1:0]   sq_prod;
  logic [micdcb_pkg::ENG_W:0]    energy_sum;
  logic [4:0]                    shamt;
  logic signed [micdcb_pkg::RAW_W-1:0] x_full;
  logic [CNT_W-1:0]              count_inc;

  micdcb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // feedback product: previous output times coefficient
  micdcb_sermul #(
    .AW       (FW),
    .BW       (micdcb_pkg::COEF_W),
    .DW       (micdcb_pkg::DIGIT_W),
    .A_SIGNED (1'b1)
  ) u_fb_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (fb_start),
    .a       (prev_out_r),
    .b       (cfg.dc_coefficient),
    .done    (fb_done),
    .product (fb_prod)
  );

  // square of the sample magnitude
  micdcb_sermul #(
    .AW       (micdcb_pkg::MAG_W),
    .BW       (micdcb_pkg::MAG_W),
    .DW       (micdcb_pkg::DIGIT_W),
    .A_SIGNED (1'b0)
  ) u_sq_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sq_start),
    .a       (mag),
    .b       (mag),
    .done    (sq_done),
    .product (sq_prod)
  );

  // capacity is the smaller of the register and the build limit
  always_comb begin
    if (32'(cfg.max_samples) > CAPACITY_LIMIT) cap = CAP_LIM;
    else                                        cap = cfg.max_samples;
  end

  assign accept      = in_valid && in_ready;
  assign path_sample = (in_data.operation == micdcb_pkg::OP_SAMPLE) && rec_r &&
                       (count_r < cap);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      micdcb_pkg::ST_IDLE: begin
        if (accept) state_nxt = path_sample ? micdcb_pkg::ST_FB : micdcb_pkg::ST_DONE;
      end
      micdcb_pkg::ST_FB: begin
        if (fb_done) state_nxt = micdcb_pkg::ST_SAT;
      end
      micdcb_pkg::ST_SAT: state_nxt = micdcb_pkg::ST_SQ;
      micdcb_pkg::ST_SQ: begin
        if (sq_done) state_nxt = micdcb_pkg::ST_DONE;
      end
      micdcb_pkg::ST_DONE: begin
        if (out_load) state_nxt = micdcb_pkg::ST_IDLE;
      end
      default: state_nxt = micdcb_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    sq_start = 1'b0;
    out_load = 1'b0;
    case (state_r)
      micdcb_pkg::ST_IDLE: in_ready = 1'b1;
      micdcb_pkg::ST_SAT:  sq_start = 1'b1;
      micdcb_pkg::ST_DONE: out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  assign fb_start = accept && path_sample;

  // input scaling, filter sum and saturation
  always_comb begin
    shamt  = micdcb_pkg::BASE_SHIFT - 5'(cfg.gain_bits);
    x_full = in_data.raw_word >>> shamt;
    fb     = $signed(fb_prod[PROD_W-1:micdcb_pkg::FB_SHIFT]);
    y_sum  = Y_W'(x_r) - Y_W'(prev_in_r) + Y_W'(fb);
    if (y_r < micdcb_pkg::PCM_MIN)      y_sat = micdcb_pkg::PCM_MIN;
    else if (y_r > micdcb_pkg::PCM_MAX) y_sat = micdcb_pkg::PCM_MAX;
    else                                y_sat = y_r;
    if (y_r[Y_W-1]) mag = micdcb_pkg::MAG_W'(-y_sat);
    else            mag = micdcb_pkg::MAG_W'(y_sat);
    count_inc  = count_r + 1'b1;
    energy_sum = {1'b0, energy_r} + (micdcb_pkg::ENG_W + 1)'(sq_prod);
  end

  // state updates per phase of an item
  always_comb begin
    prev_in_nxt  = prev_in_r;
    prev_out_nxt = prev_out_r;
    rec_nxt      = rec_r;
    count_nxt    = count_r;
    peak_nxt     = peak_r;
    energy_nxt   = energy_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    pcm_nxt      = pcm_r;
    valid_nxt    = valid_r;
    if (accept) begin
      valid_nxt = 1'b0;
      pcm_nxt   = '0;
      case (in_data.operation)
        micdcb_pkg::OP_START: begin
          prev_in_nxt  = '0;
          prev_out_nxt = '0;
          count_nxt    = '0;
          peak_nxt     = '0;
          energy_nxt   = '0;
          rec_nxt      = 1'b1;
        end
        micdcb_pkg::OP_STOP: rec_nxt = 1'b0;
        micdcb_pkg::OP_SAMPLE: begin
          if (rec_r) begin
            if (count_r >= cap) begin
              rec_nxt = 1'b0;
            end else begin
              x_nxt     = x_full[X_W-1:0];
              valid_nxt = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
    if (state_r == micdcb_pkg::ST_FB && fb_done) begin
      y_nxt        = y_sum;
      prev_in_nxt  = x_r;
      prev_out_nxt = y_sum[FW-1:0];
    end
    if (state_r == micdcb_pkg::ST_SAT) begin
      pcm_nxt   = y_sat[micdcb_pkg::PCM_W-1:0];
      if (mag > peak_r) peak_nxt = mag;
      count_nxt = count_inc;
      rec_nxt   = (count_inc < cap);
    end
    if (state_r == micdcb_pkg::ST_SQ && sq_done) begin
      if (energy_sum[micdcb_pkg::ENG_W]) energy_nxt = micdcb_pkg::ENERGY_MAX;
      else                               energy_nxt = energy_sum[micdcb_pkg::ENG_W-1:0];
    end
  end

  // output register
  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (out_load) begin
      out_valid_nxt               = 1'b1;
      out_data_nxt.pcm_sample     = $signed(pcm_r);
      out_data_nxt.sample_valid   = valid_r;
      out_data_nxt.is_recording   = rec_r;
      out_data_nxt.samples_stored = count_r;
      out_data_nxt.peak_level     = peak_r;
      out_data_nxt.energy_sum     = energy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= micdcb_pkg::ST_IDLE;
      prev_in_r   <= '0;
      prev_out_r  <= '0;
      rec_r       <= 1'b0;
      count_r     <= '0;
      peak_r      <= '0;
      energy_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prev_in_r   <= prev_in_nxt;
      prev_out_r  <= prev_out_nxt;
      rec_r       <= rec_nxt;
      count_r     <= count_nxt;
      peak_r      <= peak_nxt;
      energy_r    <= energy_nxt;
      out_valid_r <= out_valid_nxt;
    end
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    pcm_r      <= pcm_nxt;
    valid_r    <= valid_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // feedback product only completes while the filter waits for it
  a_fb_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    fb_done |-> state_r == micdcb_pkg::ST_FB)
    else $error("feedback product finished outside its wait state");

  // square only completes while the energy update waits for it
  a_sq_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    sq_done |-> state_r == micdcb_pkg::ST_SQ)
    else $error("square finished outside its wait state");

  // a stored sample always shows a nonzero count
  a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.sample_valid |-> out_data_r.samples_stored != '0)
    else $error("stored sample reported with zero count");

  // peak only drops when a start was taken
  a_peak_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (peak_r < $past(peak_r)) |->
      $past(accept && in_data.operation == micdcb_pkg::OP_START))
    else $error("peak level dropped without a start");

endmodule

// ===== rtl/micdcb_sermul.sv =====
module micdcb_sermul #(
  parameter int AW       = 32,
  parameter int BW       = 10,
  parameter int DW       = 8,
  parameter bit A_SIGNED = 1'b1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic             done,
  output logic [AW+BW-1:0] product
);

  localparam int PW   = AW + BW;
  localparam int NDIG = AW / DW;
  localparam int CW   = $clog2(NDIG + 1);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          first_r, first_nxt;
  logic          done_r, done_nxt;
  logic [AW-1:0] a_sh_r, a_sh_nxt;
  logic [BW-1:0] b_r, b_nxt;
  logic [PW-1:0] acc_r, acc_nxt;

  logic [DW-1:0]         digit;
  logic                  dsign;
  logic signed [DW:0]    dig_s;
  logic signed [BW:0]    b_s;
  logic signed [DW+BW+1:0] pp;
  logic [PW-1:0]         pp_ext;
  logic [PW-1:0]         base;

  // partial product of the top digit; the first digit carries the sign
  always_comb begin
    digit  = a_sh_r[AW-1 -: DW];
    dsign  = A_SIGNED && first_r && digit[DW-1];
    dig_s  = $signed({dsign, digit});
    b_s    = $signed({1'b0, b_r});
    pp     = dig_s * b_s;
    pp_ext = PW'(pp);
    base   = first_r ? '0 : (acc_r << DW);
  end

  // MSB-first shift-add, one digit per cycle
  always_comb begin
    cnt_nxt   = cnt_r;
    first_nxt = first_r;
    a_sh_nxt  = a_sh_r;
    b_nxt     = b_r;
    acc_nxt   = acc_r;
    done_nxt  = 1'b0;
    if (start) begin
      a_sh_nxt  = a;
      b_nxt     = b;
      cnt_nxt   = CW'(NDIG);
      first_nxt = 1'b1;
    end else if (cnt_r != '0) begin
      acc_nxt   = base + pp_ext;
      a_sh_nxt  = a_sh_r << DW;
      cnt_nxt   = cnt_r - 1'b1;
      first_nxt = 1'b0;
      done_nxt  = (cnt_r == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      first_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      first_r <= first_nxt;
      done_r  <= done_nxt;
    end
    a_sh_r <= a_sh_nxt;
    b_r    <= b_nxt;
    acc_r  <= acc_nxt;
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

// ===== rtl/micdcb_regs.sv =====
module micdcb_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [micdcb_pkg::PADDR_W-1:0]  paddr,
  input  logic [micdcb_pkg::PDATA_W-1:0]  pwdata,
  output logic [micdcb_pkg::PDATA_W-1:0]  prdata,
  output logic                            pready,
  output micdcb_pkg::cfg_t                cfg
);

  micdcb_pkg::cfg_t cfg_r, cfg_nxt;
  logic             wr_en;
  logic [1:0]       idx;

  assign wr_en = psel && penable && pwrite;
  assign idx   = paddr[3:2];

  // register write
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        micdcb_pkg::REG_GAIN: cfg_nxt.gain_bits = pwdata[micdcb_pkg::GAIN_W-1:0];
        micdcb_pkg::REG_COEF: cfg_nxt.dc_coefficient = pwdata[micdcb_pkg::COEF_W-1:0];
        micdcb_pkg::REG_MAX:  cfg_nxt.max_samples = pwdata[micdcb_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    case (idx)
      micdcb_pkg::REG_GAIN: prdata = micdcb_pkg::PDATA_W'(cfg_r.gain_bits);
      micdcb_pkg::REG_COEF: prdata = micdcb_pkg::PDATA_W'(cfg_r.dc_coefficient);
      micdcb_pkg::REG_MAX:  prdata = micdcb_pkg::PDATA_W'(cfg_r.max_samples);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_bits      <= micdcb_pkg::GAIN_RESET;
      cfg_r.dc_coefficient <= micdcb_pkg::COEF_RESET;
      cfg_r.max_samples    <= micdcb_pkg::MAX_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign pready = 1'b1;
  assign cfg    = cfg_r;

endmodule

// ===== sim/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAP_LIMIT    = 1048576;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam int          IDLE_LIMIT   = 5000;  // cycles with no handshake at all
  localparam int          LONG_HOLD    = 400;   // receiver hold-off for the pressure test
  localparam int          DRAIN_CYCLES = 16;    // a little over the longest item latency

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  logic                            in_ready;
  micdcb_pkg::in_item_t            in_data   = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  micdcb_pkg::out_item_t           out_data;
  logic                            psel      = 1'b0;
  logic                            penable   = 1'b0;
  logic                            pwrite    = 1'b0;
  logic [micdcb_pkg::PADDR_W-1:0]  paddr     = '0;
  logic [micdcb_pkg::PDATA_W-1:0]  pwdata    = '0;
  logic [micdcb_pkg::PDATA_W-1:0]  prdata;
  logic                            pready;

  mic_sample_dc_block_capture_unit #(
    .CAPACITY_LIMIT(CAP_LIMIT)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // capture model: settings and filter/statistics state
  logic [micdcb_pkg::GAIN_W-1:0]  mdl_gain  = micdcb_pkg::GAIN_RESET;
  logic [micdcb_pkg::COEF_W-1:0]  mdl_coef  = micdcb_pkg::COEF_RESET;
  logic [micdcb_pkg::CNT_W-1:0]   mdl_max   = micdcb_pkg::MAX_RESET;
  logic [31:0]                    last_x    = '0;
  logic [31:0]                    last_y    = '0;
  logic                           recording = 1'b0;
  logic [micdcb_pkg::CNT_W-1:0]   stored    = '0;
  logic [micdcb_pkg::MAG_W-1:0]   peak      = '0;
  logic [micdcb_pkg::ENG_W-1:0]   energy    = '0;

  micdcb_pkg::out_item_t pending_results[$];
  int                    mismatches = 0;
  bit                    gaps_on = 1'b1;
  bit                    long_hold_req = 1'b0;
  logic signed [31:0]    dc_level = '0;

  // one command through the capture model; returns the expected result
  function automatic micdcb_pkg::out_item_t capture_step(micdcb_pkg::in_item_t it);
    micdcb_pkg::out_item_t r;
    longint    cap, x, fb, y, mag, sq;
    r   = '0;
    cap = (mdl_max < CAP_LIMIT) ? longint'(mdl_max) : longint'(CAP_LIMIT);
    if (it.operation == micdcb_pkg::OP_START) begin
      last_x    = '0;
      last_y    = '0;
      stored    = '0;
      peak      = '0;
      energy    = '0;
      recording = 1'b1;
    end else if (it.operation == micdcb_pkg::OP_STOP) begin
      recording = 1'b0;
    end else if (it.operation == micdcb_pkg::OP_SAMPLE && recording) begin
      if (stored >= cap) begin
        // full already: refuse and stop
        recording = 1'b0;
      end else begin
        x  = longint'($signed(it.raw_word)) >>> (16 - int'(mdl_gain));
        fb = (longint'($signed(last_y)) * longint'(mdl_coef)) >>> micdcb_pkg::FB_SHIFT;
        y  = x - longint'($signed(last_x)) + fb;
        last_x = x[31:0];
        last_y = y[31:0];  // unclamped, wraps at 32 bits
        if (y < 0) begin
          if (y < -32768) y = -32768;
          mag = -y;
        end else begin
          if (y > 32767) y = 32767;
          mag = y;
        end
        r.pcm_sample   = y[15:0];
        r.sample_valid = 1'b1;
        if (mag > peak) peak = mag[15:0];
        sq = mag * mag;
        if (longint'(micdcb_pkg::ENERGY_MAX) - longint'(energy) < sq)
          energy = micdcb_pkg::ENERGY_MAX;
        else
          energy = energy + sq[micdcb_pkg::ENG_W-1:0];
        stored = stored + 1'b1;
        if (stored >= cap) recording = 1'b0;
      end
    end
    r.is_recording   = recording;
    r.samples_stored = stored;
    r.peak_level     = peak;
    r.energy_sum     = energy;
    return r;
  endfunction

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // microphone word: full range, quiet, extremes or DC offset plus noise
  function automatic logic [31:0] rand_raw();
    logic signed [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 5))
      0, 1: ;
      2: w = w >>> $urandom_range(8, 28);
      3: begin
        case ($urandom_range(0, 3))
          0:       w = 32'h7FFF_FFFF;
          1:       w = 32'h8000_0000;
          2:       w = '0;
          default: w = '1;
        endcase
      end
      default: w = dc_level + (w >>> 20);
    endcase
    return w;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] mismatch %s: got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic check_result(input micdcb_pkg::out_item_t got);
    micdcb_pkg::out_item_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result with nothing pending", 64'(got.samples_stored), '0);
    end else begin
      want = pending_results.pop_front();
      if (got.pcm_sample !== want.pcm_sample)
        report_mismatch("pcm_sample", 64'(got.pcm_sample), 64'(want.pcm_sample));
      if (got.sample_valid !== want.sample_valid)
        report_mismatch("sample_valid", 64'(got.sample_valid), 64'(want.sample_valid));
      if (got.is_recording !== want.is_recording)
        report_mismatch("is_recording", 64'(got.is_recording), 64'(want.is_recording));
      if (got.samples_stored !== want.samples_stored)
        report_mismatch("samples_stored", 64'(got.samples_stored),
                        64'(want.samples_stored));
      if (got.peak_level !== want.peak_level)
        report_mismatch("peak_level", 64'(got.peak_level), 64'(want.peak_level));
      if (got.energy_sum !== want.energy_sum)
        report_mismatch("energy_sum", 64'(got.energy_sum), 64'(want.energy_sum));
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result(out_data);
  end

  // receiver: random stalls, plus a long hold-off on request
  int ready_hold = 0;
  always @(posedge clk) begin
    int g;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        ready_hold    = LONG_HOLD;
      end
      if (ready_hold > 0) begin
        out_ready <= 1'b0;
        ready_hold--;
      end else begin
        g = pick_gap();
        if (g > 0 && $urandom_range(0, 2) == 0) begin
          out_ready <= 1'b0;
          ready_hold = g - 1;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  // watchdog on handshake activity
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("mic_sample_dc_block_capture_unit verification failed");
      $finish;
    end
  end

  // send one item; valid stays high into the next item when there is no gap
  task automatic send_item(input logic [1:0] op, input logic [31:0] raw);
    micdcb_pkg::in_item_t it;
    int       gap;
    it.operation = op;
    it.raw_word  = raw;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(capture_step(it));
  endtask

  task automatic idle_until_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // setup and access phases, then idle before the next transfer
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      micdcb_pkg::REG_GAIN: mdl_gain = value[micdcb_pkg::GAIN_W-1:0];
      micdcb_pkg::REG_COEF: mdl_coef = value[micdcb_pkg::COEF_W-1:0];
      micdcb_pkg::REG_MAX:  mdl_max  = value[micdcb_pkg::CNT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(input int unsigned g, input int unsigned c, input int unsigned m);
    idle_until_drained();
    write_reg(micdcb_pkg::REG_GAIN, g);
    write_reg(micdcb_pkg::REG_COEF, c);
    write_reg(micdcb_pkg::REG_MAX, m);
  endtask

  // reset settings, every command, word extremes, restart and ignored items
  task automatic test_default_capture();
    send_item(micdcb_pkg::OP_SAMPLE, 32'h1234_5678);  // not recording: ignored
    send_item(OP_UNUSED, $urandom);
    send_item(micdcb_pkg::OP_STOP, 32'h0);
    send_item(micdcb_pkg::OP_START, $urandom);
    send_item(micdcb_pkg::OP_SAMPLE, 32'h7FFF_FFFF);
    send_item(micdcb_pkg::OP_SAMPLE, 32'h8000_0000);
    send_item(micdcb_pkg::OP_SAMPLE, 32'h0000_0000);
    send_item(micdcb_pkg::OP_SAMPLE, 32'hFFFF_FFFF);
    send_item(micdcb_pkg::OP_SAMPLE, 32'h0010_0000);
    send_item(OP_UNUSED, 32'hFFFF_FFFF);
    send_item(micdcb_pkg::OP_START, 32'h0);           // restart while recording
    send_item(micdcb_pkg::OP_SAMPLE, 32'h4000_0000);
    send_item(micdcb_pkg::OP_SAMPLE, 32'hF000_0000);
    send_item(micdcb_pkg::OP_STOP, 32'hFFFF_FFFF);
    send_item(micdcb_pkg::OP_SAMPLE, 32'h7FFF_FFFF);  // after stop: ignored
  endtask

  // capacity reached, capacity zero, single sample, largest gain
  task automatic test_capacity_limits();
    set_config(7, 1023, 2);
    send_item(micdcb_pkg::OP_START, 32'h0);
    send_item(micdcb_pkg::OP_SAMPLE, 32'h7FFF_FFFF);
    send_item(micdcb_pkg::OP_SAMPLE, 32'h8000_0000);  // fills capacity, recording stops
    send_item(micdcb_pkg::OP_SAMPLE, 32'h7FFF_FFFF);
    set_config(0, 0, 0);
    send_item(micdcb_pkg::OP_START, 32'h0);
    send_item(micdcb_pkg::OP_SAMPLE, 32'h1234_0000);  // nothing fits: refused, stops
    set_config(3, 512, 1);
    send_item(micdcb_pkg::OP_START, 32'h0);
    send_item(micdcb_pkg::OP_SAMPLE, 32'h8765_4321);
    send_item(micdcb_pkg::OP_SAMPLE, 32'h0123_4567);
  endtask

  // receiver holds off while the sender keeps offering, then sender drains
  task automatic test_output_backpressure();
    set_config(5, 1013, 1048576);
    gaps_on = 1'b0;
    long_hold_req = 1'b1;
    send_item(micdcb_pkg::OP_START, 32'h0);
    repeat (14) send_item(micdcb_pkg::OP_SAMPLE, rand_raw());
    idle_until_drained();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_capture();
    int unsigned g, c, m, useful;
    int          r;
    logic [1:0]  op;
    bit          was_recording;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin g = 7; c = 0;    m = 21'h1F_FFFF; end
        1: begin g = 0; c = 1023; m = 1;           end
        2: begin g = 4; c = 1013; m = 0;           end
        3: begin g = 7; c = 1023; m = CAP_LIMIT;   end
        default: begin
          g = $urandom_range(0, 7);
          c = $urandom_range(0, 1023);
          m = $urandom_range(1, 80);
        end
      endcase
      set_config(g, c, m);
      gaps_on  = (ph % 3) != 2;
      dc_level = $urandom;
      dc_level = dc_level >>> $urandom_range(2, 12);
      useful   = 0;
      while (useful < 100) begin
        r = $urandom_range(0, 99);
        if (!recording && r < 85) op = micdcb_pkg::OP_START;
        else if (r < 4)           op = micdcb_pkg::OP_START;
        else if (r < 8)           op = micdcb_pkg::OP_STOP;
        else if (r < 10)          op = OP_UNUSED;
        else                      op = micdcb_pkg::OP_SAMPLE;
        was_recording = recording;
        send_item(op, rand_raw());
        if (!(op == OP_UNUSED || (op == micdcb_pkg::OP_SAMPLE && !was_recording)))
          useful++;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_capture();
    test_capacity_limits();
    test_output_backpressure();
    test_random_capture();
    idle_until_drained();
    if (mismatches == 0) begin
      $display("mic_sample_dc_block_capture_unit verification clean");
    end else begin
      $display("mic_sample_dc_block_capture_unit verification failed");
    end
    $finish;
  end

endmodule
